@@ src/bhed_pkg.sv @@
// Shared types and constants for the button history event detector.
package bhed_pkg;

  localparam int NUM_BUTTONS   = 16;
  localparam int HISTORY_DEPTH = 60;
  localparam int SLOT_W        = 6;
  localparam int TAP_W         = 3;

  localparam logic [9:0] WINDOW_MAX_MS = 10'd1000;

  // Reciprocals: F = (3W * 1311) >> 16 = floor(3W/50), T = (9W * 5243) >> 20 = floor(9W/200)
  localparam logic [10:0] RECIP_F = 11'd1311;
  localparam int          SHIFT_F = 16;
  localparam logic [12:0] RECIP_T = 13'd5243;
  localparam int          SHIFT_T = 20;

  typedef enum logic [2:0] {
    EV_LEVEL  = 3'd0,
    EV_DOWN   = 3'd1,
    EV_HELD   = 3'd2,
    EV_UP     = 3'd3,
    EV_IDLE   = 3'd4,
    EV_REPEAT = 3'd5,
    EV_CLICK  = 3'd6,
    EV_DOUBLE = 3'd7
  } event_kind_t;

  // Order in which the history taps are read.
  localparam logic [TAP_W-1:0] TAP_B0   = 3'd0;
  localparam logic [TAP_W-1:0] TAP_B1   = 3'd1;
  localparam logic [TAP_W-1:0] TAP_F    = 3'd2;
  localparam logic [TAP_W-1:0] TAP_H    = 3'd3;
  localparam logic [TAP_W-1:0] TAP_T    = 3'd4;
  localparam logic [TAP_W-1:0] TAP_Q    = 3'd5;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_Q;

  typedef struct packed {
    logic             load;      // capture the input item
    logic             rec_wr;    // store a recorded frame
    logic             mul_en;    // register the offset products
    logic             rd_en;     // read one history tap
    logic [TAP_W-1:0] tap_sel;
    logic             out_load;  // load the result register
  } bhed_cmd_t;

  typedef struct packed {
    logic out_full;
  } bhed_status_t;

endpackage

@@ src/bhed_ctrl.sv @@
// Controller: sequences record writes, offset products and history tap reads.
module bhed_ctrl
  import bhed_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_op,
  output logic         in_stall,
  input  logic         out_stall,
  input  bhed_status_t status,
  output bhed_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_REC   = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_TAP   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !status.out_full || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load     = accept;
    cmd.tap_sel  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_op ? ST_MUL : ST_REC;
        end
      end
      ST_REC: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = TAP_B0;
        state_nxt  = ST_TAP;
      end
      ST_TAP: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == TAP_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ src/bhed_dp.sv @@
// Datapath: frame history memory, tap offsets, tap bits and result register.
module bhed_dp
  import bhed_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  bhed_cmd_t     cmd,
  output bhed_status_t  status,
  input  logic          in_op,
  input  logic [15:0]   in_buttons,
  input  logic [3:0]    in_button_index,
  input  logic [2:0]    in_event_kind,
  input  logic [9:0]    in_window_ms,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_hit
);

  logic [NUM_BUTTONS-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r;

  logic [SLOT_W-1:0]      newest_r;
  logic                   op_r;
  logic [NUM_BUTTONS-1:0] buttons_r;
  logic [3:0]             idx_r;
  event_kind_t            kind_r;
  logic [9:0]             win_r;

  logic [21:0] prod_f_r;
  logic [25:0] prod_t_r;
  logic [SLOT_W-1:0] off_f, off_h, off_q, off_t, off_k;

  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W:0]   rd_sum;
  logic [SLOT_W-1:0] rd_addr;

  logic [NUM_BUTTONS-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_pend_r;
  logic [TAP_W-1:0]       sel_d_r;
  logic                   tap_bit;

  logic b0_r, b1_r, bf_r, bh_r, bt_r, bq_r;
  logic hit_calc;
  logic out_valid_r, hit_r;

  // Input capture; window saturates at the maximum.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      buttons_r <= in_buttons;
      idx_r     <= in_button_index;
      kind_r    <= event_kind_t'(in_event_kind);
      win_r     <= (in_window_ms > WINDOW_MAX_MS) ? WINDOW_MAX_MS : in_window_ms;
    end
  end

  // Offsets via reciprocal multiply; H and Q follow from F by halving.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_f_r <= 22'(({2'b0, win_r} + {1'b0, win_r, 1'b0}) * RECIP_F);
      prod_t_r <= 26'(({4'b0, win_r} + {1'b0, win_r, 3'b0}) * RECIP_T);
    end
  end

  assign off_f = prod_f_r[SHIFT_F +: SLOT_W];
  assign off_h = {1'b0, off_f[SLOT_W-1:1]};
  assign off_q = {2'b0, off_f[SLOT_W-1:2]};
  assign off_t = prod_t_r[SHIFT_T +: SLOT_W];

  always_comb begin
    case (cmd.tap_sel)
      TAP_B0:  off_k = '0;
      TAP_B1:  off_k = 6'd1;
      TAP_F:   off_k = off_f;
      TAP_H:   off_k = off_h;
      TAP_T:   off_k = off_t;
      TAP_Q:   off_k = off_q;
      default: off_k = '0;
    endcase
  end

  // Slot k frames back, modulo the depth; an offset equal to the depth wraps to zero.
  assign rd_sum  = {1'b0, newest_r} + (7'(HISTORY_DEPTH) - {1'b0, off_k});
  assign rd_addr = (rd_sum >= 7'(HISTORY_DEPTH)) ?
                   SLOT_W'(rd_sum - 7'(HISTORY_DEPTH)) : rd_sum[SLOT_W-1:0];
  assign wr_slot = (newest_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : newest_r + 6'd1;

  always_ff @(posedge clk) begin
    if (cmd.rec_wr) begin
      mem[wr_slot] <= buttons_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
      sel_d_r   <= cmd.tap_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      newest_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      if (cmd.rec_wr) begin
        vld_r[wr_slot] <= 1'b1;
        newest_r       <= wr_slot;
      end
    end
  end

  // Slots never written read as zero.
  assign tap_bit = rd_vld_r && rd_data_r[idx_r];

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      case (sel_d_r)
        TAP_B0:  b0_r <= tap_bit;
        TAP_B1:  b1_r <= tap_bit;
        TAP_F:   bf_r <= tap_bit;
        TAP_H:   bh_r <= tap_bit;
        TAP_T:   bt_r <= tap_bit;
        TAP_Q:   bq_r <= tap_bit;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kind_r)
      EV_LEVEL:  hit_calc = b0_r;
      EV_DOWN:   hit_calc = !b1_r && b0_r;
      EV_HELD:   hit_calc = b1_r && b0_r;
      EV_UP:     hit_calc = b1_r && !b0_r;
      EV_IDLE:   hit_calc = !b1_r && !b0_r;
      EV_REPEAT: hit_calc = bf_r && bh_r && b0_r;
      EV_CLICK:  hit_calc = !bf_r && bh_r && !b0_r;
      EV_DOUBLE: hit_calc = !bf_r && bt_r && !bh_r && bq_r && !b0_r;
      default:   hit_calc = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit_r <= op_r && hit_calc;
    end
  end

  assign status.out_full = out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;

endmodule

@@ src/button_history_event_detector.sv @@
// Button history event detector: record frames into a 60-deep history, answer event queries.
//
// A record item (op 0) stores the button vector as the newest of the last 60 frames; a
// query item (op 1) answers hit for one button and event kind (level, down, held, up,
// idle, repeat, click, double click) from that button's bits at fixed frame offsets back
// from the newest frame, derived from window_ms at 60 frames per second (window capped at
// 1000 ms, offsets taken modulo 60). Every item gives exactly one result; hit is 0 for a
// record. The history memory has one read port, so a query reads six taps from it one
// per cycle, after the offset multiplies are registered. The next item is taken once the
// result is loaded into the output register. The history reads as all zeros after reset.
module button_history_event_detector
  import bhed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_buttons,
  input  logic [3:0]  in_button_index,
  input  logic [2:0]  in_event_kind,
  input  logic [9:0]  in_window_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit
);

  bhed_cmd_t    cmd;
  bhed_status_t status;

  bhed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bhed_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_op           (in_op),
    .in_buttons      (in_buttons),
    .in_button_index (in_button_index),
    .in_event_kind   (in_event_kind),
    .in_window_ms    (in_window_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the button history event detector.
`timescale 1ns / 100ps

module tb_top;
  import bhed_pkg::*;

  localparam bit OP_RECORD = 1'b0;
  localparam bit OP_QUERY  = 1'b1;

  localparam int RAND_ITEMS  = 400;
  localparam int CALM_START  = 340;  // no idling on either side from here on
  localparam int PAUSE_POINT = 200;

  // Tracks the frame history and holds the hit values still due from the block.
  class hit_scoreboard;
    logic [NUM_BUTTONS-1:0] frames [HISTORY_DEPTH];
    int unsigned            newest;
    bit                     due_hits[$];
    int                     errors;
    int                     n_records;
    int                     n_queries;
    int                     n_hits;

    function new();
      foreach (frames[i]) frames[i] = '0;
      newest    = 0;
      errors    = 0;
      n_records = 0;
      n_queries = 0;
      n_hits    = 0;
    endfunction

    function bit frame_bit(int unsigned btn, int unsigned back);
      int unsigned slot;
      slot = (newest + HISTORY_DEPTH - back % HISTORY_DEPTH) % HISTORY_DEPTH;
      return frames[slot][btn];
    endfunction

    function void note_item(bit op, logic [15:0] btn_vec, logic [3:0] idx,
                            logic [2:0] kind, logic [9:0] win);
      int unsigned w, f, h, q, t;
      bit b0, b1, hit;
      hit = 1'b0;
      if (op == OP_RECORD) begin
        newest = (newest + 1) % HISTORY_DEPTH;
        frames[newest] = btn_vec[NUM_BUTTONS-1:0];
        n_records++;
      end else begin
        n_queries++;
        if (idx < NUM_BUTTONS) begin
          w = (win > WINDOW_MAX_MS) ? WINDOW_MAX_MS : win;
          f = (w * 6) / 100;
          h = (w * 12) / 400;
          q = (w * 6) / 400;
          t = (w * 18) / 400;
          b0 = frame_bit(idx, 0);
          b1 = frame_bit(idx, 1);
          case (event_kind_t'(kind))
            EV_LEVEL:  hit = b0;
            EV_DOWN:   hit = !b1 && b0;
            EV_HELD:   hit = b1 && b0;
            EV_UP:     hit = b1 && !b0;
            EV_IDLE:   hit = !b1 && !b0;
            EV_REPEAT: hit = frame_bit(idx, f) && frame_bit(idx, h) && b0;
            EV_CLICK:  hit = !frame_bit(idx, f) && frame_bit(idx, h) && !b0;
            default:   hit = !frame_bit(idx, f) && frame_bit(idx, t) &&
                             !frame_bit(idx, h) && frame_bit(idx, q) && !b0;
          endcase
        end
      end
      due_hits.push_back(hit);
    endfunction

    function void check_hit(logic got);
      bit want;
      if (due_hits.size() == 0) begin
        $error("unexpected result transfer: hit expected none, actual %0b", got);
        errors++;
      end else begin
        want = due_hits.pop_front();
        if (got !== want) begin
          $error("hit mismatch: expected %0b, actual %0b", want, got);
          errors++;
        end
        if (want) n_hits++;
      end
    endfunction

    function int pending();
      return due_hits.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_op           = 1'b0;
  logic [15:0] in_buttons      = '0;
  logic [3:0]  in_button_index = '0;
  logic [2:0]  in_event_kind   = '0;
  logic [9:0]  in_window_ms    = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic        out_hit;

  hit_scoreboard sb = new();
  bit            idle_en = 1'b1;

  button_history_event_detector u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_buttons      (in_buttons),
    .in_button_index (in_button_index),
    .in_event_kind   (in_event_kind),
    .in_window_ms    (in_window_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Result side: check each transfer, stall in short random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_hit(out_hit);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input bit op, input logic [15:0] btn_vec, input logic [3:0] idx,
                           input logic [2:0] kind, input logic [9:0] win);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_buttons      <= btn_vec;
    in_button_index <= idx;
    in_event_kind   <= kind;
    in_window_ms    <= win;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, btn_vec, idx, kind, win);
  endtask

  task automatic record(input logic [15:0] btn_vec);
    send_item(OP_RECORD, btn_vec, 4'($urandom), 3'($urandom), 10'($urandom));
  endtask

  task automatic query(input logic [3:0] idx, input event_kind_t kind, input logic [9:0] win);
    send_item(OP_QUERY, 16'($urandom), idx, kind, win);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_window();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 10'($urandom_range(1001, 1023));
    if (sel == 1) return WINDOW_MAX_MS;
    if (sel == 2) return 10'($urandom_range(0, 40));
    return 10'($urandom_range(0, 1000));
  endfunction

  initial begin
    int          n_items;
    int          n_rec;
    int          n_qry;
    bit          paused;
    logic [15:0] cur;
    logic [15:0] flip;

    n_items = 0;
    paused  = 1'b0;
    cur     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Queries on an empty history.
    query(4'd0, EV_LEVEL, 10'd0);
    query(4'd15, EV_IDLE, 10'd0);
    query(4'd7, EV_DOUBLE, 10'd1023);
    // Button 0 pattern 0,0,1,0,0,1,0 oldest first: a double click at 100 ms.
    record(16'h0000);
    record(16'h0000);
    record(16'h0001);
    record(16'h0000);
    record(16'h0000);
    record(16'h0001);
    record(16'h0000);
    query(4'd0, EV_DOUBLE, 10'd100);
    query(4'd0, EV_CLICK, 10'd100);
    query(4'd0, EV_UP, 10'd0);
    query(4'd0, EV_DOWN, 10'd0);
    // 1000 ms puts the far tap 60 frames back, which aliases the newest frame.
    query(4'd0, EV_REPEAT, 10'd1000);
    record(16'hFFFF);
    query(4'd15, EV_DOWN, 10'd0);
    query(4'd15, EV_LEVEL, 10'd0);
    record(16'hFFFF);
    query(4'd15, EV_HELD, 10'd0);
    query(4'd15, EV_REPEAT, 10'd1001);
    query(4'd8, EV_IDLE, 10'd1023);
    wait_drained();

    while (n_items < RAND_ITEMS) begin
      if (!paused && n_items >= PAUSE_POINT) begin
        wait_drained();
        paused = 1'b1;
      end
      if (n_items >= CALM_START) idle_en = 1'b0;
      // A run of frames where each button toggles now and then, then a few queries.
      n_rec = $urandom_range(0, 6);
      repeat (n_rec) begin
        case ($urandom_range(0, 9))
          0:       flip = 16'($urandom);
          1, 2, 3: flip = 16'($urandom & $urandom & $urandom & $urandom);
          default: flip = 16'($urandom & $urandom);
        endcase
        cur = cur ^ flip;
        record(cur);
        n_items++;
      end
      n_qry = $urandom_range(1, 3);
      repeat (n_qry) begin
        query(4'($urandom), event_kind_t'($urandom_range(0, 7)), pick_window());
        n_items++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d record and %0d query transfers, %0d queries hit.",
             sb.n_records, sb.n_queries, sb.n_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/bhed_pkg.sv
src/bhed_ctrl.sv
src/bhed_dp.sv
src/button_history_event_detector.sv
test/tb_top.sv
